[design/ofs_pkg.sv]
// ----------------------------------------------------------------------------
// ofs_pkg
// Shared types and constants of the outlier fraction selector.
// ----------------------------------------------------------------------------
package ofs_pkg;

    localparam int DEF_MAX_CHANNELS = 256;
    localparam int VAR_W            = 32;
    localparam int TOT_W            = 48;
    localparam int CNT_OUT_W        = 9;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_METRIC_MODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_THRESHOLD = 2'd2;

    localparam logic [8:0]  RST_CHANNEL_COUNT   = 9'd128;
    localparam logic [1:0]  RST_METRIC_MODE     = 2'd0;
    localparam logic [15:0] RST_RATIO_THRESHOLD = 16'd512;

    localparam logic [1:0] MODE_MODERATE = 2'd0;
    localparam logic [1:0] MODE_MAX      = 2'd1;
    localparam logic [1:0] MODE_TOTAL    = 2'd2;
    localparam logic [1:0] MODE_HYBRID   = 2'd3;

    localparam logic [1:0] CODE_NONE    = 2'd0;
    localparam logic [1:0] CODE_EIGHTH  = 2'd1;
    localparam logic [1:0] CODE_QUARTER = 2'd2;
    localparam logic [1:0] CODE_HALF    = 2'd3;

    localparam logic [VAR_W-1:0] RATIO_ONE = 32'h0001_0000;

    typedef struct packed {
        logic             last;
        logic [TOT_W-1:0] med_total;
        logic [TOT_W-1:0] total;
        logic [VAR_W-1:0] variance;
    } t_entry;

    typedef struct packed {
        logic                 degenerate;
        logic [CNT_OUT_W-1:0] strong_cnt;
        logic [CNT_OUT_W-1:0] moderate;
        logic [VAR_W-1:0]     ratio;
        logic [1:0]           code;
    } t_result;

endpackage

[design/ofs_ram.sv]
// ----------------------------------------------------------------------------
// ofs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ofs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/ofs_front.sv]
// ----------------------------------------------------------------------------
// ofs_front
// Accepts items, marks the last one of each set and queues them.
// ----------------------------------------------------------------------------
module ofs_front #(
    parameter int CW = 9
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [CW-1:0]  i_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [ofs_pkg::VAR_W-1:0] i_variance,
    input  logic [ofs_pkg::TOT_W-1:0] i_total,
    input  logic [ofs_pkg::TOT_W-1:0] i_med_total,
    output logic           o_q_valid,
    input  logic           i_q_pop,
    output ofs_pkg::t_entry o_q_entry
);

    localparam int DEPTH = 4;

    ofs_pkg::t_entry r_q [DEPTH];
    logic [1:0]      r_wp, r_rp;
    logic [2:0]      r_fill;
    logic [CW-1:0]   r_cnt;
    logic            w_push, w_pop, w_last;

    assign o_ready   = (r_fill != 3'(DEPTH));
    assign w_push    = i_valid && o_ready;
    assign w_pop     = i_q_pop && (r_fill != 3'd0);
    assign w_last    = ({1'b0, r_cnt} + 1'b1) >= {1'b0, i_n};
    assign o_q_valid = (r_fill != 3'd0);
    assign o_q_entry = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wp  <= r_wp + 1'b1;
                r_cnt <= w_last ? '0 : r_cnt + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_fill <= r_fill + 3'(w_push) - 3'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{last: w_last, med_total: i_med_total,
                           total: i_total, variance: i_variance};
        end
    end

endmodule

[design/ofs_back.sv]
// ----------------------------------------------------------------------------
// ofs_back
// Insertion sort into RAM, then median, ratio division, count sweep and
// fraction code for each finished set.
// ----------------------------------------------------------------------------
module ofs_back #(
    parameter int MAX_CHANNELS = 256,
    parameter int CW = 9
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [CW-1:0]   i_n,
    input  logic [1:0]      i_mode,
    input  logic [15:0]     i_thr,
    input  logic            i_q_valid,
    output logic            o_q_pop,
    input  ofs_pkg::t_entry i_q_entry,
    output logic            o_valid,
    input  logic            i_ready,
    output ofs_pkg::t_result o_result
);

    localparam int AW = $clog2(MAX_CHANNELS);
    localparam int MW = CW + 5;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_RD   = 11'b00000000010,
        S_CMP  = 11'b00000000100,
        S_POST = 11'b00000001000,
        S_RMAX = 11'b00000010000,
        S_RMED = 11'b00000100000,
        S_CAPM = 11'b00001000000,
        S_MUL  = 11'b00010000000,
        S_DIV  = 11'b00100000000,
        S_SWP  = 11'b01000000000,
        S_FIN  = 11'b10000000000
    } t_state;

    t_state          r_state;
    ofs_pkg::t_entry r_e;
    logic [AW-1:0]   r_loaded, r_pos;
    logic [31:0]     r_max, r_med;
    logic [47:0]     r_thrmed;
    logic [34:0]     r_m5;
    logic [39:0]     r_plo, r_phi;
    logic [32:0]     r_rem;
    logic [47:0]     r_dvd, r_quo;
    logic [5:0]      r_dcnt;
    logic [CW-1:0]   r_idx, r_mod, r_strong;
    logic            r_rv, r_sweep;
    logic            r_ov;
    ofs_pkg::t_result r_res, r_out;

    logic            w_we;
    logic [AW-1:0]   w_waddr, w_raddr;
    logic [31:0]     w_wdata, w_rdata;
    logic [32:0]     w_rem_t;
    logic [63:0]     w_tvprod;
    logic [MW-1:0]   w_m16, w_m8, w_n1, w_n3;
    logic [1:0]      w_from_mod, w_from_max, w_code;

    ofs_ram #(.WIDTH(ofs_pkg::VAR_W), .DEPTH(MAX_CHANNELS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign o_valid  = r_ov;
    assign o_result = r_out;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos;
        w_wdata = r_e.variance;
        w_raddr = r_pos - 1'b1;
        unique case (r_state)
            S_RD: begin
                w_we = (r_pos == '0);
            end
            S_CMP: begin
                w_we = 1'b1;
                if (w_rdata < r_e.variance) begin
                    w_wdata = w_rdata;
                end
            end
            S_RMAX: w_raddr = '0;
            S_RMED: w_raddr = AW'(i_n >> 1);
            S_SWP:  w_raddr = AW'(r_idx);
            default: ;
        endcase
    end

    assign w_rem_t = {r_rem[31:0], r_dvd[47]};
    assign w_tvprod = {r_phi, 24'b0} + {24'b0, r_plo};

    assign w_m16 = MW'(r_mod) << 4;
    assign w_m8  = MW'(r_mod) << 3;
    assign w_n1  = MW'(i_n);
    assign w_n3  = MW'(i_n) + (MW'(i_n) << 1);

    always_comb begin
        priority if (w_m16 < w_n1)      w_from_mod = ofs_pkg::CODE_NONE;
        else if (w_m16 < w_n3)          w_from_mod = ofs_pkg::CODE_EIGHTH;
        else if (w_m8 < w_n3)           w_from_mod = ofs_pkg::CODE_QUARTER;
        else                            w_from_mod = ofs_pkg::CODE_HALF;
        w_from_max = ({8'b0, r_max, 8'b0} > r_thrmed) ? ofs_pkg::CODE_QUARTER
                                                     : ofs_pkg::CODE_NONE;
        unique case (i_mode)
            ofs_pkg::MODE_MAX:    w_code = w_from_max;
            ofs_pkg::MODE_TOTAL: begin
                if (r_e.med_total == '0) begin
                    w_code = ofs_pkg::CODE_NONE;
                end else begin
                    w_code = ({8'b0, r_e.total, 8'b0} > w_tvprod)
                           ? ofs_pkg::CODE_QUARTER : ofs_pkg::CODE_NONE;
                end
            end
            ofs_pkg::MODE_HYBRID: w_code = (w_from_mod > w_from_max) ? w_from_mod
                                                                    : w_from_max;
            default:              w_code = w_from_mod;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_loaded <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (r_ov && i_ready && r_state != S_FIN) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_e     <= i_q_entry;
                        r_pos   <= r_loaded;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= (r_pos == '0) ? S_POST : S_CMP;
                end
                S_CMP: begin
                    if (w_rdata < r_e.variance) begin
                        r_pos   <= r_pos - 1'b1;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    if (r_e.last) begin
                        r_loaded <= '0;
                        r_state  <= S_RMAX;
                    end else begin
                        r_loaded <= r_loaded + 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_RMAX: r_state <= S_RMED;
                S_RMED: begin
                    r_max   <= w_rdata;
                    r_state <= S_CAPM;
                end
                S_CAPM: begin
                    r_med <= w_rdata;
                    if (w_rdata == '0) begin
                        r_res   <= '{degenerate: 1'b1, strong_cnt: '0, moderate: '0,
                                     ratio: ofs_pkg::RATIO_ONE, code: ofs_pkg::CODE_NONE};
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_thrmed <= i_thr * r_med;
                    r_m5     <= {3'b0, r_med} + {1'b0, r_med, 2'b0};
                    r_plo    <= i_thr * r_e.med_total[23:0];
                    r_phi    <= i_thr * r_e.med_total[47:24];
                    r_rem    <= '0;
                    r_dvd    <= {r_max, 16'b0};
                    r_quo    <= '0;
                    r_dcnt   <= '0;
                    r_idx    <= '0;
                    r_mod    <= '0;
                    r_strong <= '0;
                    r_rv     <= 1'b0;
                    r_sweep  <= 1'b0;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (w_rem_t >= {1'b0, r_med}) begin
                        r_rem <= w_rem_t - {1'b0, r_med};
                        r_quo <= {r_quo[46:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_t;
                        r_quo <= {r_quo[46:0], 1'b0};
                    end
                    r_dvd  <= {r_dvd[46:0], 1'b0};
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 6'd47) begin
                        r_state <= S_SWP;
                    end
                end
                S_SWP: begin
                    if (r_idx < i_n) begin
                        r_idx <= r_idx + 1'b1;
                        r_rv  <= 1'b1;
                    end else begin
                        r_rv <= 1'b0;
                    end
                    if (r_rv) begin
                        if ({3'b0, w_rdata} > r_m5) begin
                            r_strong <= r_strong + 1'b1;
                        end
                        if ({8'b0, w_rdata, 8'b0} > r_thrmed) begin
                            r_mod <= r_mod + 1'b1;
                        end
                    end
                    if (r_idx == i_n && !r_rv) begin
                        r_sweep <= 1'b1;
                    end
                    if (r_sweep) begin
                        r_res   <= '{degenerate: 1'b0,
                                     strong_cnt: ofs_pkg::CNT_OUT_W'(r_strong),
                                     moderate: ofs_pkg::CNT_OUT_W'(r_mod),
                                     ratio: (r_quo[47:32] != '0) ? 32'hFFFF_FFFF
                                                                 : r_quo[31:0],
                                     code: w_code};
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_ov || i_ready) begin
                        r_out   <= r_res;
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[design/outlier_fraction_selector.sv]
// ----------------------------------------------------------------------------
// outlier_fraction_selector
// Sorts one set of channel variances and reports the outlier fraction code.
// ----------------------------------------------------------------------------
// Input stream: one channel variance per item with the layer totals; a set is
// channel_count items (clamped to 1..MAX_CHANNELS). One result item leaves on
// the output stream per set. The user writes registers through i_cfg_* only
// while idle; the block itself does not enforce it.
// A four-entry queue decouples acceptance from the sorting back end, so input
// is taken at one item a cycle until the queue fills.
// Each item is inserted into the descending RAM list by a shift loop through
// the RAM port: S_RD and S_CMP move smaller entries down one position until
// the item's place is found, and S_POST ends the insertion.
// After the last item the states S_RMAX, S_RMED, S_CAPM and S_MUL fetch
// maximum and median and form the products, S_DIV runs restoring division
// for the ratio, S_SWP runs the count sweep and S_FIN loads the output
// register; a zero median goes straight from S_CAPM to S_FIN.
// Reset clears the queue, the load count and the output valid flag, but not
// the RAM or the output data. While the receiver stalls the result is held in
// the output register and the back end waits with the next result ready.
// ----------------------------------------------------------------------------
module outlier_fraction_selector #(
    parameter int MAX_CHANNELS = ofs_pkg::DEF_MAX_CHANNELS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [ofs_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [ofs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // channel_variance[31:0], layer_total_variance[79:32],
    // median_layer_variance[127:80]
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // fraction_code[1:0], peak_ratio[33:2], moderate_count[42:34],
    // strong_count[51:43], zero fill [55:52]
    output logic [55:0]  m_axis_tdata,
    // degenerate[0]
    output logic         m_axis_tuser
);

    localparam int CW = $clog2(MAX_CHANNELS + 1);

    logic [8:0]  r_cc;
    logic [1:0]  r_mode;
    logic [15:0] r_thr;
    logic [31:0] w_cc32, w_n32;
    logic [CW-1:0] w_n;

    logic            w_q_valid, w_q_pop;
    ofs_pkg::t_entry w_q_entry;
    ofs_pkg::t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc   <= ofs_pkg::RST_CHANNEL_COUNT;
            r_mode <= ofs_pkg::RST_METRIC_MODE;
            r_thr  <= ofs_pkg::RST_RATIO_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ofs_pkg::CFG_CHANNEL_COUNT:   r_cc   <= i_cfg_wdata[8:0];
                ofs_pkg::CFG_METRIC_MODE:     r_mode <= i_cfg_wdata[1:0];
                ofs_pkg::CFG_RATIO_THRESHOLD: r_thr  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_cc32 = {23'b0, r_cc};
    assign w_n32  = (w_cc32 == 32'd0) ? 32'd1
                  : ((w_cc32 > 32'(MAX_CHANNELS)) ? 32'(MAX_CHANNELS) : w_cc32);
    assign w_n    = w_n32[CW-1:0];

    ofs_front #(.CW(CW)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_n        (w_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_variance (s_axis_tdata[31:0]),
        .i_total    (s_axis_tdata[79:32]),
        .i_med_total(s_axis_tdata[127:80]),
        .o_q_valid  (w_q_valid),
        .i_q_pop    (w_q_pop),
        .o_q_entry  (w_q_entry)
    );

    ofs_back #(.MAX_CHANNELS(MAX_CHANNELS), .CW(CW)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_n      (w_n),
        .i_mode   (r_mode),
        .i_thr    (r_thr),
        .i_q_valid(w_q_valid),
        .o_q_pop  (w_q_pop),
        .i_q_entry(w_q_entry),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_res)
    );

    assign m_axis_tdata = {4'b0, w_res.strong_cnt, w_res.moderate, w_res.ratio, w_res.code};
    assign m_axis_tuser = w_res.degenerate;

endmodule
